@@ rtl/escape_coded_patch_decoder_core_assert.svh @@
// Assertion macros shared by the patch decoder RTL.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef ESCAPE_CODED_PATCH_DECODER_CORE_ASSERT_SVH
`define ESCAPE_CODED_PATCH_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ECPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("patch decoder assertion failed");

// Next-cycle implication, disabled during reset.
`define ECPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("patch decoder assertion failed");

`endif

@@ rtl/ecpd_pkg.sv @@
// Shared types and constants of the escape-coded patch decoder.
// Depends on nothing; used by ecpd_step and the top level.
package ecpd_pkg;

	// Decode phase, one-hot.
	typedef enum logic [7:0] {
		PH_PLAIN = 8'b0000_0001,
		PH_ESC   = 8'b0000_0010,
		PH_S16A  = 8'b0000_0100,
		PH_S16B  = 8'b0000_1000,
		PH_S32A  = 8'b0001_0000,
		PH_S32B  = 8'b0010_0000,
		PH_S32C  = 8'b0100_0000,
		PH_S32D  = 8'b1000_0000
	} phase_t;

	localparam logic [7:0]  ESC_BYTE   = 8'hFF;
	localparam logic [7:0]  ZERO_BYTE  = 8'h00;
	localparam logic [15:0] SKIP16_EXT = 16'hFFFF;
	localparam logic [31:0] PATCH_STOP = 32'hFFFF_FFFF;
	localparam int unsigned ACC_BITS   = 24;

	// One result item as held in the output stage.
	typedef struct packed {
		logic        patch_end;
		logic [7:0]  write_data;
		logic [31:0] write_offset;
	} result_t;

endpackage

@@ rtl/escape_coded_patch_decoder_core.sv @@
// Escape-coded patch decoder: one patch byte in, at most one write item out.
// Results are held in the output register, or in the skid entry while that is stalled.
// Throughput: one byte per cycle while the skid entry is empty.
// A two-entry output stage (register plus skid) keeps input flowing while a result waits.
// Reset (arst_n low, asynchronous): plain phase, offset zero, output stage empty.
// Depends on ecpd_pkg, ecpd_step and the assertion header.
`include "escape_coded_patch_decoder_core_assert.svh"
module escape_coded_patch_decoder_core #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] patch_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] write_offset, [39:32] write_data
	output logic        m_tlast    // patch_end
);
	ecpd_pkg::phase_t                  phase_q;
	ecpd_pkg::phase_t                  phase_nxt;
	logic [OFFSET_BITS-1:0]            offset_q;
	logic [OFFSET_BITS-1:0]            offset_nxt;
	logic [ecpd_pkg::ACC_BITS-1:0]     acc_q;
	logic [ecpd_pkg::ACC_BITS-1:0]     acc_nxt;
	logic                              res_valid;
	ecpd_pkg::result_t                 res;
	ecpd_pkg::result_t                 out_q;
	ecpd_pkg::result_t                 skid_q;
	logic                              out_valid_q;
	logic                              skid_valid_q;
	logic                              accept;
	logic                              produce;
	logic                              taken;

	ecpd_step #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_step (
		.phase      (phase_q),
		.offset     (offset_q),
		.acc        (acc_q),
		.patch_byte (s_tdata),
		.phase_nxt  (phase_nxt),
		.offset_nxt (offset_nxt),
		.acc_nxt    (acc_nxt),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign produce  = accept && res_valid;
	assign taken    = out_valid_q && m_tready;

	// Decoder state advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ecpd_pkg::PH_PLAIN;
			offset_q <= '0;
			acc_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_nxt;
			offset_q <= offset_nxt;
			acc_q    <= acc_nxt;
		end
	end

	// Output register and skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (taken) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= produce;
			end
		end else if (out_valid_q) begin
			if (produce) begin
				skid_valid_q <= 1'b1;
			end
		end else begin
			out_valid_q <= produce;
		end
	end

	// Payload of the output stage; no reset needed.
	always_ff @(posedge clk) begin
		if (taken && skid_valid_q) begin
			out_q <= skid_q;
		end else if (produce && (taken || !out_valid_q)) begin
			out_q <= res;
		end
		if (produce && out_valid_q && !taken) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.write_data, out_q.write_offset};
	assign m_tlast  = out_q.patch_end;

	// The skid entry is only ever filled behind a full output register.
	`ECPD_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
	// A result arriving at a stalled, full output register lands in the skid entry.
	`ECPD_ASSERT_NEXT(a_stall_fills_skid, produce && out_valid_q && !m_tready, skid_valid_q)
	// A terminator item restarts decoding at offset zero in the plain phase.
	`ECPD_ASSERT_NEXT(a_end_restarts, produce && res.patch_end,
		(offset_q == '0) && (phase_q == ecpd_pkg::PH_PLAIN))

endmodule

@@ rtl/ecpd_step.sv @@
// Next-state and result logic for one patch byte.
// Depends on ecpd_pkg.
module ecpd_step #(
	parameter int OFFSET_BITS = 32
) (
	input  ecpd_pkg::phase_t                  phase,
	input  logic [OFFSET_BITS-1:0]            offset,
	input  logic [ecpd_pkg::ACC_BITS-1:0]     acc,
	input  logic [7:0]                        patch_byte,
	output ecpd_pkg::phase_t                  phase_nxt,
	output logic [OFFSET_BITS-1:0]            offset_nxt,
	output logic [ecpd_pkg::ACC_BITS-1:0]     acc_nxt,
	output logic                              res_valid,
	output ecpd_pkg::result_t                 res
);
	localparam int AW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

	logic [AW-1:0]  off_ext;
	logic [AW-1:0]  sum;
	logic [31:0]    amount;
	logic [15:0]    v16;
	logic [31:0]    v32;
	logic           stop;

	assign off_ext = AW'(offset);
	assign v16     = {acc[7:0], patch_byte};
	assign v32     = {acc, patch_byte};
	assign sum     = off_ext + AW'(amount);

	// Phase transitions, skip amount and result selection.
	always_comb begin
		phase_nxt      = phase;
		acc_nxt        = acc;
		amount         = 32'd0;
		stop           = 1'b0;
		res_valid      = 1'b0;
		res.patch_end  = 1'b0;
		res.write_data = patch_byte;
		res.write_offset = off_ext[31:0];
		unique case (phase)
			ecpd_pkg::PH_PLAIN: begin
				if (patch_byte == ecpd_pkg::ESC_BYTE) begin
					phase_nxt = ecpd_pkg::PH_ESC;
				end else begin
					res_valid = 1'b1;
					amount    = 32'd1;
				end
			end
			ecpd_pkg::PH_ESC: begin
				phase_nxt = ecpd_pkg::PH_PLAIN;
				if (patch_byte == ecpd_pkg::ZERO_BYTE) begin
					res_valid      = 1'b1;
					res.write_data = ecpd_pkg::ESC_BYTE;
					amount         = 32'd1;
				end else if (patch_byte == ecpd_pkg::ESC_BYTE) begin
					phase_nxt = ecpd_pkg::PH_S16A;
				end else begin
					amount = 32'(patch_byte);
				end
			end
			ecpd_pkg::PH_S16A: begin
				acc_nxt   = ecpd_pkg::ACC_BITS'(patch_byte);
				phase_nxt = ecpd_pkg::PH_S16B;
			end
			ecpd_pkg::PH_S16B: begin
				acc_nxt = '0;
				if (v16 == ecpd_pkg::SKIP16_EXT) begin
					phase_nxt = ecpd_pkg::PH_S32A;
				end else begin
					amount    = 32'(v16);
					phase_nxt = ecpd_pkg::PH_PLAIN;
				end
			end
			ecpd_pkg::PH_S32A: begin
				acc_nxt   = ecpd_pkg::ACC_BITS'(patch_byte);
				phase_nxt = ecpd_pkg::PH_S32B;
			end
			ecpd_pkg::PH_S32B: begin
				acc_nxt   = {acc[15:0], patch_byte};
				phase_nxt = ecpd_pkg::PH_S32C;
			end
			ecpd_pkg::PH_S32C: begin
				acc_nxt   = {acc[15:0], patch_byte};
				phase_nxt = ecpd_pkg::PH_S32D;
			end
			ecpd_pkg::PH_S32D: begin
				acc_nxt   = '0;
				phase_nxt = ecpd_pkg::PH_PLAIN;
				if (v32 == ecpd_pkg::PATCH_STOP) begin
					stop           = 1'b1;
					res_valid      = 1'b1;
					res.patch_end  = 1'b1;
					res.write_data = ecpd_pkg::ZERO_BYTE;
				end else begin
					amount = v32;
				end
			end
			default: begin
				phase_nxt = ecpd_pkg::PH_PLAIN;
			end
		endcase
	end

	// The offset wraps at its own width; the end of a patch returns it to zero.
	assign offset_nxt = stop ? '0 : sum[OFFSET_BITS-1:0];

endmodule
